FILE: rtl/core/oeh_pkg.sv
// Package for the Euler / Heun ODE integrator core.
// Holds parameter defaults, configuration register indexes and the divider status type.
// No dependencies.
`default_nettype none

package oeh_pkg;

  localparam int MAX_STEPS_DEF = 128;
  localparam int FRAC_BITS_DEF = 24;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EQUATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD   = 1'b1;

  // step divider: one quotient bit per cycle
  localparam int DIV_BITS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/oeh_div.sv
// Restoring divider for the step size: 32-bit unsigned dividend by an 8-bit divisor.
// One quotient bit per cycle, quotient valid when the done strobe is high.
// Depends on oeh_pkg.
`default_nettype none

module oeh_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [31:0]        dividend,
  input  wire logic [7:0]         divisor,
  output oeh_pkg::div_stat_t      div_stat,
  output logic [31:0]             quotient
);
  import oeh_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]          quo_r, quo_nxt;
  logic [7:0]           rem_r, rem_nxt;
  logic [7:0]           dvs_r, dvs_nxt;
  logic [8:0]           trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract where it fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 8'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[7:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = DIV_CNT_W'(cnt_r + 1'b1);
      if (cnt_r == DIV_CNT_W'(DIV_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign div_stat.busy = busy_r;
  assign div_stat.done = done_r;
  assign quotient      = quo_r;

endmodule

`default_nettype wire

FILE: rtl/core/ode_euler_heun_integrator_core.sv
// Euler / Heun integrator for dy/dx = 2xy or x^2+y^2 in signed fixed point.
// The step divider runs first, then n steps on one shared 32x32 multiplier; x^2+y^2
// adds a sum state to each slope, and Heun evaluates the slope twice per step.
// The result strobe is high in the cycle after the last step.
// One item at a time: busy is high from the accepting edge to the result edge.
// Reset (synchronous, active low) returns the sequencer to idle and clears both configuration registers to 0.
`default_nettype none

module ode_euler_heun_integrator_core #(
  parameter int MAX_STEPS = oeh_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = oeh_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [31:0]             in_target_x,
  input  wire logic [7:0]                     in_num_steps,
  output logic                                out_valid,
  output logic signed [31:0]                  out_y_value,
  output logic                                out_overflow,
  input  wire logic                           cfg_we,
  input  wire logic [oeh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [oeh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import oeh_pkg::*;

  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam logic signed [31:0] Y0_HALF = 32'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] Y0_ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF_XY = 64'sd1 <<< (FRAC_BITS - 2);
  localparam logic signed [63:0] HALF_Q  = 64'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DIV  = 11'b000_0000_0010,
    S_MX   = 11'b000_0000_0100,
    S_WX   = 11'b000_0000_1000,
    S_SA   = 11'b000_0001_0000,
    S_SB   = 11'b000_0010_0000,
    S_SC   = 11'b000_0100_0000,
    S_K    = 11'b000_1000_0000,
    S_WK   = 11'b001_0000_0000,
    S_MID  = 11'b010_0000_0000,
    S_UPD  = 11'b100_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_XY   = 2'd1,
    SH_Q    = 2'd2
  } shift_t;

  // saturate to 32 bits; bit 32 of the result flags saturation
  function automatic logic [32:0] sat64(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] sat_add(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    return sat64(64'(a) + 64'(b));
  endfunction

  state_t                state_r, state_nxt;
  logic                  equation_r, method_r;
  logic signed [31:0]    h_r, h_nxt;
  logic signed [31:0]    y_r, y_nxt;
  logic signed [31:0]    sx_r, sx_nxt;
  logic signed [31:0]    sy_r, sy_nxt;
  logic signed [31:0]    slope_r, slope_nxt;
  logic signed [31:0]    xx_r, xx_nxt;
  logic signed [31:0]    k1_r, k1_nxt;
  logic signed [31:0]    k2_r, k2_nxt;
  logic signed [63:0]    prod_r;
  logic [NW-1:0]         i_r, i_nxt;
  logic [NW-1:0]         n_r, n_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  phase_r, phase_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [31:0]    out_y_r, out_y_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic signed [31:0]    mul_a, mul_b;
  shift_t                sh_sel;
  logic signed [63:0]    rnd;
  logic [32:0]           post;
  logic [32:0]           t_a, t_b;
  logic [31:0]           nsel;
  logic [31:0]           mag;
  logic                  div_start;
  div_stat_t             div_stat;
  logic [31:0]           div_quo;
  logic                  last_step;

  assign busy = (state_r != S_IDLE);

  // clamp the step count and take the magnitude of the target
  always_comb begin
    nsel = (in_num_steps == 8'd0) ? 32'd1 : 32'(in_num_steps);
    if (nsel > 32'(MAX_STEPS)) begin
      nsel = 32'(MAX_STEPS);
    end
    mag = in_target_x[31] ? 32'(32'd0 - in_target_x) : in_target_x;
  end

  oeh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (8'(nsel)),
    .div_stat (div_stat),
    .quotient (div_quo)
  );

  // shared multiplier operands and the scaling of its registered product
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    sh_sel = SH_NONE;
    unique case (state_r)
      S_MX: begin
        mul_a = $signed(32'(i_r));
        mul_b = h_r;
      end
      S_SA: begin
        mul_a = sx_r;
        mul_b = equation_r ? sx_r : sy_r;
      end
      S_SB: begin
        mul_a  = sy_r;
        mul_b  = sy_r;
        sh_sel = equation_r ? SH_Q : SH_XY;
      end
      S_K: begin
        mul_a = h_r;
        mul_b = slope_r;
      end
      S_SC, S_WK: sh_sel = SH_Q;
      default: sh_sel = SH_NONE;
    endcase
  end

  always_comb begin
    case (sh_sel)
      SH_XY:   rnd = (prod_r + HALF_XY) >>> (FRAC_BITS - 1);
      SH_Q:    rnd = (prod_r + HALF_Q) >>> FRAC_BITS;
      default: rnd = prod_r;
    endcase
    post = sat64(rnd);
  end

  assign last_step = (NW'(i_r + 1'b1) == n_r);

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    y_nxt         = y_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    slope_nxt     = slope_r;
    xx_nxt        = xx_r;
    k1_nxt        = k1_r;
    k2_nxt        = k2_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    phase_nxt     = phase_r;
    out_valid_nxt = 1'b0;
    out_y_nxt     = out_y_r;
    out_ovf_nxt   = out_ovf_r;
    div_start     = 1'b0;
    t_a           = '0;
    t_b           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          div_start = 1'b1;
          n_nxt     = NW'(nsel);
          ovf_nxt   = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          t_a       = sat64($signed({32'd0, div_quo}));
          h_nxt     = t_a[31:0];
          ovf_nxt   = ovf_r | t_a[32];
          y_nxt     = equation_r ? Y0_ONE : Y0_HALF;
          i_nxt     = '0;
          phase_nxt = 1'b0;
          state_nxt = S_MX;
        end
      end
      S_MX: state_nxt = S_WX;
      S_WX: begin
        sx_nxt    = post[31:0];
        sy_nxt    = y_r;
        ovf_nxt   = ovf_r | post[32];
        state_nxt = S_SA;
      end
      S_SA: state_nxt = S_SB;
      S_SB: begin
        ovf_nxt = ovf_r | post[32];
        if (equation_r) begin
          xx_nxt    = post[31:0];
          state_nxt = S_SC;
        end else begin
          slope_nxt = post[31:0];
          state_nxt = S_K;
        end
      end
      S_SC: begin
        t_a       = sat_add(xx_r, post[31:0]);
        slope_nxt = t_a[31:0];
        ovf_nxt   = ovf_r | post[32] | t_a[32];
        state_nxt = S_K;
      end
      S_K: state_nxt = S_WK;
      S_WK: begin
        ovf_nxt = ovf_r | post[32];
        if (phase_r) begin
          k2_nxt    = post[31:0];
          state_nxt = S_UPD;
        end else begin
          k1_nxt    = post[31:0];
          state_nxt = method_r ? S_MID : S_UPD;
        end
      end
      S_MID: begin
        // corrector point: x + h, y + k1
        t_a       = sat_add(sx_r, h_r);
        t_b       = sat_add(sy_r, k1_r);
        sx_nxt    = t_a[31:0];
        sy_nxt    = t_b[31:0];
        ovf_nxt   = ovf_r | t_a[32] | t_b[32];
        phase_nxt = 1'b1;
        state_nxt = S_SA;
      end
      S_UPD: begin
        if (method_r) begin
          t_a = sat64(64'(y_r) + ((64'(k1_r) + 64'(k2_r) + 64'sd1) >>> 1));
        end else begin
          t_a = sat_add(y_r, k1_r);
        end
        y_nxt     = t_a[31:0];
        ovf_nxt   = ovf_r | t_a[32];
        phase_nxt = 1'b0;
        if (last_step) begin
          out_valid_nxt = 1'b1;
          out_y_nxt     = t_a[31:0];
          out_ovf_nxt   = ovf_r | t_a[32];
          state_nxt     = S_IDLE;
        end else begin
          i_nxt     = NW'(i_r + 1'b1);
          state_nxt = S_MX;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      n_r         <= '0;
      phase_r     <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      n_r         <= n_nxt;
      phase_r     <= phase_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= mul_a * mul_b;
    h_r       <= h_nxt;
    y_r       <= y_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    slope_r   <= slope_nxt;
    xx_r      <= xx_nxt;
    k1_r      <= k1_nxt;
    k2_r      <= k2_nxt;
    out_y_r   <= out_y_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  // configuration registers: bit 0 of the write data is kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      equation_r <= 1'b0;
      method_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EQUATION: equation_r <= cfg_wdata[0];
        CFG_METHOD:   method_r   <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_y_value  = out_y_r;
  assign out_overflow = out_ovf_r;

  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DIV && div_stat.busy))
    else $error("accepted item did not start the step divider");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> state_r == S_DIV)
    else $error("divider active outside the divide state");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_UPD))
    else $error("result strobe not preceded by a final update");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_DIV) |-> (i_r < n_r))
    else $error("step index beyond step count");

endmodule

`default_nettype wire

FILE: bench/tb_ode_euler_heun_integrator_core.sv
// Self-checking bench for ode_euler_heun_integrator_core: directed corners, then random
// targets and step counts under every equation/method setting and several sender idle rates.
// Depends on oeh_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_ode_euler_heun_integrator_core;

  localparam int FB = oeh_pkg::FRAC_BITS_DEF;
  localparam int STEP_CAP = oeh_pkg::MAX_STEPS_DEF;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS_PER_BLOCK = 38;

  typedef struct {
    logic signed [31:0] y;
    logic               ovf;
  } y_end_t;

  // Integrates each accepted item in fixed point and holds the final y values in order.
  class y_end_tracker;
    bit          eq_sel;
    bit          meth_sel;
    bit          sat_seen;
    y_end_t      y_end_q[$];
    int unsigned n_items;
    int unsigned n_checked;
    int unsigned n_ovf;
    int unsigned n_bad;

    function new();
      eq_sel   = 1'b0;
      meth_sel = 1'b0;
      n_items  = 0;
      n_checked = 0;
      n_ovf    = 0;
      n_bad    = 0;
    endfunction

    function void set_reg(logic [oeh_pkg::CFG_IDX_W-1:0] idx, logic val);
      case (idx)
        oeh_pkg::CFG_EQUATION: eq_sel = val;
        oeh_pkg::CFG_METHOD:   meth_sel = val;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > Q_MAX) begin
        sat_seen = 1'b1;
        return Q_MAX;
      end
      if (v < Q_MIN) begin
        sat_seen = 1'b1;
        return Q_MIN;
      end
      return v;
    endfunction

    // round to nearest, ties towards plus infinity
    function longint rnd_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint fx_mul(longint a, longint b, int s);
      return clamp32(rnd_shift(a * b, s));
    endfunction

    function longint slope(longint x, longint y);
      longint xx;
      longint yy;
      if (eq_sel) begin
        xx = fx_mul(x, x, FB);
        yy = fx_mul(y, y, FB);
        return clamp32(xx + yy);
      end
      return fx_mul(x, y, FB - 1);
    endfunction

    function void take_item(logic signed [31:0] target, logic [7:0] steps);
      logic [31:0] mag32;
      longint      mag;
      longint      n;
      longint      h;
      longint      y;
      longint      x;
      longint      k1;
      longint      k2;
      y_end_t      e;
      sat_seen = 1'b0;
      mag32 = target[31] ? 32'd0 - target : target;
      mag = longint'(mag32);
      n = longint'(steps);
      if (n == 0) n = 1;
      if (n > STEP_CAP) n = STEP_CAP;
      h = clamp32(mag / n);
      y = eq_sel ? (64'sd1 <<< FB) : (64'sd1 <<< (FB - 1));
      for (longint i = 0; i < n; i++) begin
        // x is formed as i*h, never accumulated
        x = clamp32(i * h);
        k1 = fx_mul(h, slope(x, y), FB);
        if (!meth_sel) begin
          y = clamp32(y + k1);
        end else begin
          k2 = fx_mul(h, slope(clamp32(x + h), clamp32(y + k1)), FB);
          y = clamp32(y + rnd_shift(k1 + k2, 1));
        end
      end
      e.y = y[31:0];
      e.ovf = sat_seen;
      y_end_q.push_back(e);
      n_items++;
    endfunction

    function void check_y(logic signed [31:0] y, logic ovf);
      y_end_t e;
      if (y_end_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("[%0t] result y=%h ovf=%b with no item outstanding", $time, y, ovf);
        return;
      end
      e = y_end_q.pop_front();
      n_checked++;
      if (e.ovf) n_ovf++;
      if (y !== e.y || ovf !== e.ovf) begin
        n_bad++;
        if (n_bad <= 10)
          $display("[%0t] result %0d: y exp %h got %h, overflow exp %b got %b",
                   $time, n_checked, e.y, y, e.ovf, ovf);
      end
    endfunction

    function int unsigned pending();
      return y_end_q.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic signed [31:0]               in_target_x;
  logic [7:0]                       in_num_steps;
  logic                             out_valid;
  logic signed [31:0]               out_y_value;
  logic                             out_overflow;
  logic                             cfg_we;
  logic [oeh_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [oeh_pkg::CFG_DATA_W-1:0]   cfg_wdata;

  y_end_tracker board;
  int unsigned  idle_pct;
  int unsigned  quiet_cycles;

  ode_euler_heun_integrator_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_target_x  (in_target_x),
    .in_num_steps (in_num_steps),
    .out_valid    (out_valid),
    .out_y_value  (out_y_value),
    .out_overflow (out_overflow),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sample every transfer on the edge that completes it
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.set_reg(cfg_index, cfg_wdata[0]);
      if (start && !busy) board.take_item(in_target_x, in_num_steps);
      if (out_valid) board.check_y(out_y_value, out_overflow);
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("ode_euler_heun_integrator_core verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic sender_gap();
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      // sometimes hold off until the core has gone idle, so the gap lands after busy falls
      if ($urandom_range(2) == 0) begin
        do @(posedge clk); while (busy);
      end else begin
        @(posedge clk);
      end
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic signed [31:0] t, input logic [7:0] s);
    sender_gap();
    start <= 1'b1;
    in_target_x <= t;
    in_num_steps <= s;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic eq_v, input logic meth_v);
    cfg_we <= 1'b1;
    cfg_index <= oeh_pkg::CFG_EQUATION;
    cfg_wdata <= eq_v;
    @(posedge clk);
    cfg_index <= oeh_pkg::CFG_METHOD;
    cfg_wdata <= meth_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_target();
    int unsigned sel;
    logic [31:0] r;
    sel = $urandom_range(99);
    if (sel < 35) begin
      r = $urandom_range(32'h0800_0000);
      return r - 32'h0400_0000;
    end
    if (sel < 55) begin
      r = $urandom_range(32'h0200_0000);
      return r - 32'h0100_0000;
    end
    if (sel < 80) return $urandom;
    if (sel < 90) begin
      case ($urandom_range(5))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh8000_0001;
        3: return 32'sh0;
        4: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    r = $urandom_range(32'h2000_0000);
    return r - 32'h1000_0000;
  endfunction

  function automatic logic [7:0] rand_steps();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 65) return 8'($urandom_range(12, 1));
    if (sel < 85) return 8'($urandom_range(64, 13));
    if (sel < 93) return 8'($urandom_range(255));
    return 8'($urandom_range(128, 120));
  endfunction

  initial begin
    board = new();
    start = 1'b0;
    in_target_x = '0;
    in_num_steps = 8'd1;
    cfg_we = 1'b0;
    cfg_index = oeh_pkg::CFG_EQUATION;
    cfg_wdata = '0;
    rst_n = 1'b0;
    idle_pct = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners under each setting; the first runs on the reset values
    for (int c = 0; c < 4; c++) begin
      if (c != 0) begin
        drain();
        write_cfg(c[0], c[1]);
      end
      send_item(32'sh8000_0000, 8'd1);
      send_item(32'sh7FFF_FFFF, 8'd255);
      send_item(-32'sh0100_0000, 8'd10);
      send_item(32'sh0100_0000, 8'd0);
      send_item(c[0] ? 32'sh0 : 32'sh1, 8'd129);
      send_item(32'sh0200_0000, 8'd128);
    end

    // every setting meets every idle rate across the twelve blocks
    for (int blk = 0; blk < 12; blk++) begin
      drain();
      write_cfg(blk[0], blk[1]);
      case (blk % 3)
        0: idle_pct = 0;
        1: idle_pct = 82;
        default: idle_pct = 31;
      endcase
      repeat (ITEMS_PER_BLOCK) send_item(rand_target(), rand_steps());
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Ran %0d items through all four equation/method settings at idle rates 0/31/82%%.",
             board.n_items);
    $display("Checked %0d results, %0d of them with overflow set; %0d mismatches.",
             board.n_checked, board.n_ovf, board.n_bad);
    if (board.n_bad == 0 && board.pending() == 0) begin
      $display("ode_euler_heun_integrator_core verification clean");
    end else begin
      $display("ode_euler_heun_integrator_core verification failed");
    end
    $finish;
  end

endmodule
